// ===== hdl/sample_average_aces_tonemap_macros.svh =====
// Assertion helpers shared by the block
`ifndef SAMPLE_AVERAGE_ACES_TONEMAP_MACROS_SVH
`define SAMPLE_AVERAGE_ACES_TONEMAP_MACROS_SVH

// same-cycle implication
`define SAT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sat assertion failed");

// next-cycle implication
`define SAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sat assertion failed");

`endif

// ===== hdl/sat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg
// Shared constants, widths and types of the sample average tone mapper.
// ----------------------------------------------------------------------------
package sat_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int FRAC_BITS   = 16;

	localparam int XW   = 24;                 // sample width
	localparam int SW   = 30;                 // sum and average width
	localparam int NW   = 7;                  // count width
	localparam int SEEN_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int AW   = SW + 8;             // linear term width
	localparam int ML   = 19;                 // low slice of the linear term
	localparam int PL   = SW + ML;            // partial product width
	localparam int PW   = 64;                 // curve terms, wrap at 64 bits
	localparam int DCW  = $clog2(SW + 1);     // divide step counter

	localparam logic [AW-1:0] NUM_A = AW'(251);
	localparam logic [AW-1:0] NUM_B = AW'(3 * (64'd1 << FRAC_BITS));
	localparam logic [AW-1:0] DEN_A = AW'(243);
	localparam logic [AW-1:0] DEN_B = AW'(59 * (64'd1 << FRAC_BITS));
	localparam logic [PW-1:0] DEN_C = PW'(64'd14 << (2 * FRAC_BITS));
	localparam logic [XW-1:0] ONE   = XW'(64'd1 << FRAC_BITS);

	localparam logic [0:0] REG_SPP    = 1'b0;
	localparam logic [0:0] REG_BYPASS = 1'b1;

	typedef enum logic [2:0] {
		L_IDLE,
		L_DIV,
		L_MUL1,
		L_MUL2,
		L_MUL3,
		L_CMP,
		L_SCALE,
		L_DONE
	} lane_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lane_stat_t;

endpackage

// ===== hdl/sat_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_lane
// One colour channel: divide the sum by the count, apply the filmic curve or
// bypass, and scale to a byte.
// ----------------------------------------------------------------------------
module sat_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      ack,
	input  logic [sat_pkg::SW-1:0]    sum,
	input  logic [sat_pkg::NW-1:0]    count,
	input  logic                      bypass,
	output sat_pkg::lane_stat_t       stat,
	output logic [7:0]                byte_out
);

	sat_pkg::lane_state_t state_q, state_d;

	logic [sat_pkg::SW-1:0]  quo_q;
	logic [sat_pkg::NW-1:0]  rem_q;
	logic [sat_pkg::NW-1:0]  cnt_q;
	logic [sat_pkg::DCW-1:0] step_q;
	logic                    byp_q;
	logic [sat_pkg::AW-1:0]  a_q, b_q;
	logic [sat_pkg::PW-1:0]  num_q, den_q;
	logic [sat_pkg::PW-1:0]  r_q;
	logic [7:0]              q_q;
	logic [7:0]              byte_q;

	logic [sat_pkg::NW:0]    div_t;
	logic                    div_ge;
	logic [sat_pkg::SW-1:0]  x;
	logic [sat_pkg::PW-1:0]  r_sh;
	logic                    r_ge;
	logic [31:0]             byp_prod;
	logic [sat_pkg::PL-1:0]  num_lo, num_hi, den_lo, den_hi;

	assign x       = quo_q;
	assign div_t   = {rem_q, quo_q[sat_pkg::SW-1]};
	assign div_ge  = div_t >= {1'b0, cnt_q};
	assign r_sh    = {r_q[sat_pkg::PW-2:0], 1'b0};
	assign r_ge    = r_sh >= den_q;
	assign byp_prod = 32'(x) * 32'd255;
	assign num_lo  = sat_pkg::PL'(x) * sat_pkg::PL'(a_q[sat_pkg::ML-1:0]);
	assign num_hi  = sat_pkg::PL'(x) * sat_pkg::PL'(a_q[sat_pkg::AW-1:sat_pkg::ML]);
	assign den_lo  = sat_pkg::PL'(x) * sat_pkg::PL'(b_q[sat_pkg::ML-1:0]);
	assign den_hi  = sat_pkg::PL'(x) * sat_pkg::PL'(b_q[sat_pkg::AW-1:sat_pkg::ML]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sat_pkg::L_IDLE:  if (start) state_d = sat_pkg::L_DIV;
			sat_pkg::L_DIV:   if (step_q == sat_pkg::DCW'(sat_pkg::SW - 1))
				state_d = sat_pkg::L_MUL1;
			sat_pkg::L_MUL1:  state_d = byp_q ? sat_pkg::L_DONE : sat_pkg::L_MUL2;
			sat_pkg::L_MUL2:  state_d = sat_pkg::L_MUL3;
			sat_pkg::L_MUL3:  state_d = sat_pkg::L_CMP;
			sat_pkg::L_CMP:   state_d = (num_q >= den_q) ? sat_pkg::L_DONE : sat_pkg::L_SCALE;
			sat_pkg::L_SCALE: if (step_q == sat_pkg::DCW'(7)) state_d = sat_pkg::L_DONE;
			sat_pkg::L_DONE:  if (ack) state_d = sat_pkg::L_IDLE;
			default:          state_d = sat_pkg::L_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = (state_q != sat_pkg::L_IDLE);
		stat.done = (state_q == sat_pkg::L_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sat_pkg::L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sat_pkg::L_IDLE: begin
				quo_q  <= sum;
				rem_q  <= '0;
				cnt_q  <= count;
				byp_q  <= bypass;
				step_q <= '0;
			end
			sat_pkg::L_DIV: begin
				quo_q  <= {quo_q[sat_pkg::SW-2:0], div_ge};
				rem_q  <= div_ge ? sat_pkg::NW'(div_t - {1'b0, cnt_q}) : div_t[sat_pkg::NW-1:0];
				step_q <= step_q + 1'b1;
			end
			sat_pkg::L_MUL1: begin
				a_q <= sat_pkg::AW'(x) * sat_pkg::NUM_A + sat_pkg::NUM_B;
				b_q <= sat_pkg::AW'(x) * sat_pkg::DEN_A + sat_pkg::DEN_B;
				if (x >= sat_pkg::SW'(sat_pkg::ONE)) byte_q <= 8'hFF;
				else byte_q <= byp_prod[sat_pkg::FRAC_BITS +: 8];
			end
			sat_pkg::L_MUL2: begin
				num_q <= sat_pkg::PW'(num_lo);
				den_q <= sat_pkg::PW'(den_lo) + sat_pkg::DEN_C;
			end
			sat_pkg::L_MUL3: begin
				num_q <= num_q + {num_hi[sat_pkg::PW-sat_pkg::ML-1:0], {sat_pkg::ML{1'b0}}};
				den_q <= den_q + {den_hi[sat_pkg::PW-sat_pkg::ML-1:0], {sat_pkg::ML{1'b0}}};
			end
			sat_pkg::L_CMP: begin
				r_q    <= num_q;
				q_q    <= '0;
				step_q <= '0;
				byte_q <= 8'hFF;
			end
			sat_pkg::L_SCALE: begin
				r_q    <= r_ge ? (r_sh - den_q) : r_sh;
				q_q    <= {q_q[6:0], r_ge};
				step_q <= step_q + 1'b1;
				if (step_q == sat_pkg::DCW'(7)) begin
					if ((r_ge ? (r_sh - den_q) : r_sh) < num_q)
						byte_q <= {q_q[6:0], r_ge} - 8'd1;
					else
						byte_q <= {q_q[6:0], r_ge};
				end
			end
			default: begin
			end
		endcase
	end

	assign byte_out = byte_q;

endmodule

// ===== hdl/sat_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_merge
// Join the three channel bytes into one pixel and hold it for the output.
// ----------------------------------------------------------------------------
module sat_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  sat_pkg::lane_stat_t stat_r,
	input  sat_pkg::lane_stat_t stat_g,
	input  sat_pkg::lane_stat_t stat_b,
	input  logic [7:0]          byte_r,
	input  logic [7:0]          byte_g,
	input  logic [7:0]          byte_b,
	output logic                ack,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          pixel_red,
	output logic [7:0]          pixel_green,
	output logic [7:0]          pixel_blue
);

	logic       valid_q;
	logic [7:0] red_q, green_q, blue_q;

	assign ack = stat_r.done && stat_g.done && stat_b.done && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ack) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			red_q   <= byte_r;
			green_q <= byte_g;
			blue_q  <= byte_b;
		end
	end

	assign out_valid   = valid_q;
	assign pixel_red   = red_q;
	assign pixel_green = green_q;
	assign pixel_blue  = blue_q;

endmodule

// ===== hdl/sample_average_aces_tonemap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_average_aces_tonemap
// Sums HDR samples per pixel, averages them and emits one RGB byte triple per
// pixel, tone mapped by the filmic curve or, in bypass, scaled linearly.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while a pixel accumulates. The sample that
// closes a pixel starts three channel lanes, which bring it to the output
// register through a 30-step divide by the sample count, three multiply
// stages, a compare and an 8-step scaling of the curve ratio. In bypass a
// lane is done after the first multiply stage, and a saturating channel skips
// the scaling; the handoff waits while the consumer holds the output register.
// The closing sample of the next pixel waits until the lanes have handed
// their result to the output register, which itself holds one pixel.
module sample_average_aces_tonemap (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [6:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [23:0]            sample_red,
	input  logic [23:0]            sample_green,
	input  logic [23:0]            sample_blue,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             pixel_red,
	output logic [7:0]             pixel_green,
	output logic [7:0]             pixel_blue
);

	`include "sample_average_aces_tonemap_macros.svh"

	logic [sat_pkg::NW-1:0]     spp_q;
	logic                       bypass_q;
	logic [sat_pkg::SW-1:0]     red_sum_q, green_sum_q, blue_sum_q;
	logic [sat_pkg::SEEN_W-1:0] seen_q;

	logic [sat_pkg::NW-1:0] n_eff;
	logic [sat_pkg::SW-1:0] red_nx, green_nx, blue_nx;
	logic                   final_c, accept, start, lanes_busy, ack;
	sat_pkg::lane_stat_t    stat_r, stat_g, stat_b;
	logic [7:0]             byte_r, byte_g, byte_b;

	always_comb begin
		if (spp_q == '0) n_eff = sat_pkg::NW'(1);
		else if (spp_q > sat_pkg::NW'(sat_pkg::MAX_SAMPLES)) n_eff = sat_pkg::NW'(sat_pkg::MAX_SAMPLES);
		else n_eff = spp_q;
	end

	assign red_nx     = red_sum_q + sat_pkg::SW'(sample_red);
	assign green_nx   = green_sum_q + sat_pkg::SW'(sample_green);
	assign blue_nx    = blue_sum_q + sat_pkg::SW'(sample_blue);
	assign final_c    = (sat_pkg::NW'(seen_q) + sat_pkg::NW'(1)) >= n_eff;
	assign lanes_busy = stat_r.busy || stat_g.busy || stat_b.busy;
	assign in_ready   = !final_c || !lanes_busy;
	assign accept     = in_valid && in_ready;
	assign start      = accept && final_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q    <= sat_pkg::NW'(1);
			bypass_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sat_pkg::REG_SPP:    spp_q    <= cfg_data;
				sat_pkg::REG_BYPASS: bypass_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_sum_q   <= '0;
			green_sum_q <= '0;
			blue_sum_q  <= '0;
			seen_q      <= '0;
		end else if (start) begin
			red_sum_q   <= '0;
			green_sum_q <= '0;
			blue_sum_q  <= '0;
			seen_q      <= '0;
		end else if (accept) begin
			red_sum_q   <= red_nx;
			green_sum_q <= green_nx;
			blue_sum_q  <= blue_nx;
			seen_q      <= seen_q + 1'b1;
		end
	end

	sat_lane u_lane_r (
		.clk(clk), .arst_n(arst_n), .start(start), .ack(ack), .sum(red_nx),
		.count(n_eff), .bypass(bypass_q), .stat(stat_r), .byte_out(byte_r)
	);

	sat_lane u_lane_g (
		.clk(clk), .arst_n(arst_n), .start(start), .ack(ack), .sum(green_nx),
		.count(n_eff), .bypass(bypass_q), .stat(stat_g), .byte_out(byte_g)
	);

	sat_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .start(start), .ack(ack), .sum(blue_nx),
		.count(n_eff), .bypass(bypass_q), .stat(stat_b), .byte_out(byte_b)
	);

	sat_merge u_merge (
		.clk(clk), .arst_n(arst_n),
		.stat_r(stat_r), .stat_g(stat_g), .stat_b(stat_b),
		.byte_r(byte_r), .byte_g(byte_g), .byte_b(byte_b),
		.ack(ack), .out_valid(out_valid), .out_ready(out_ready),
		.pixel_red(pixel_red), .pixel_green(pixel_green), .pixel_blue(pixel_blue)
	);

	`SAT_ASSERT_NEXT(a_clear_on_close, start, (seen_q == '0) && (red_sum_q == '0))
	`SAT_ASSERT_NEXT(a_lanes_start, start, stat_r.busy && stat_g.busy && stat_b.busy)
	`SAT_ASSERT_NOW(a_lanes_lockstep, 1'b1,
		($countones({stat_r.busy, stat_g.busy, stat_b.busy}) == 0) ||
		($countones({stat_r.busy, stat_g.busy, stat_b.busy}) == 3))
	`SAT_ASSERT_NEXT(a_ack_loads, ack, out_valid)

endmodule
